@@ hdl/dldc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldc_pkg: shared types and constants of the dual led dimmer controller
// Command codes, configuration indexes, reset values and the payload structs.
// ----------------------------------------------------------------------------
package dldc_pkg;

  localparam int LEVEL_W   = 8;
  localparam int OPCODE_W  = 4;
  localparam int STEP_W    = 8;
  localparam int TICKS_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [TICKS_W-1:0]  ticks_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam level_t LEVEL_MAX = 8'd255;
  localparam ticks_t TICKS_MAX = 16'hFFFF;

  localparam opcode_t OP_INC      = 4'd0;
  localparam opcode_t OP_DEC      = 4'd1;
  localparam opcode_t OP_ON       = 4'd2;
  localparam opcode_t OP_OFF      = 4'd3;
  localparam opcode_t OP_TOGGLE   = 4'd4;
  localparam opcode_t OP_INC2     = 4'd5;
  localparam opcode_t OP_DEC2     = 4'd6;
  localparam opcode_t OP_SYNC2    = 4'd7;
  localparam opcode_t OP_SET      = 4'd8;
  localparam opcode_t OP_SET2     = 4'd9;
  localparam opcode_t OP_OVR_ON   = 4'd10;
  localparam opcode_t OP_OVR_OFF  = 4'd11;
  localparam opcode_t OP_ACTIVITY = 4'd12;
  localparam opcode_t OP_TICK     = 4'd13;

  localparam cfg_idx_t CFG_STEP_SIZE    = 1'd0;
  localparam cfg_idx_t CFG_IDLE_TIMEOUT = 1'd1;

  localparam step_t  STEP_SIZE_RST    = 8'd16;
  localparam ticks_t IDLE_TIMEOUT_RST = 16'd60000;

  typedef struct packed {
    opcode_t opcode;
    level_t  level;
  } cmd_t;

  typedef struct packed {
    level_t main_duty;
    level_t second_duty;
    logic   is_enabled;
    logic   in_override;
  } res_t;

endpackage

@@ hdl/dldc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldc_if: request channels of the dimmer controller
// Command channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dldc_cmd_if;
  logic              valid;
  logic              ready;
  dldc_pkg::opcode_t opcode;
  dldc_pkg::level_t  level;

  modport source (output valid, output opcode, output level, input ready);
  modport sink   (input valid, input opcode, input level, output ready);
endinterface

interface dldc_res_if;
  logic             valid;
  logic             ready;
  dldc_pkg::level_t main_duty;
  dldc_pkg::level_t second_duty;
  logic             is_enabled;
  logic             in_override;

  modport source (output valid, output main_duty, output second_duty,
                  output is_enabled, output in_override, input ready);
  modport sink   (input valid, input main_duty, input second_duty,
                  input is_enabled, input in_override, output ready);
endinterface

@@ hdl/dual_led_dimmer_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_led_dimmer_controller: two-channel led brightness controller
// Command-driven dimmer with enable, override and idle timeout.
// ----------------------------------------------------------------------------
// usage:
//   cmd carries one command request (opcode, level). every accepted request
//   produces exactly one result request on res with both duties and flags,
//   taken after the command is applied.
//   a command accepted at an edge shows its result on res right after
//   that edge. throughput is one command per cycle while res is taken; the
//   state update and result are a single pass between the state registers
//   and the result register.
//   cmd.ready stays high while the result register is empty or being taken
//   in the same cycle, so a stalled receiver holds one result and stops
//   new commands until it takes it.
//   cfg_we writes step_size (index 0) or idle_timeout (index 1) from
//   cfg_data; write only while no request is in flight.
//   reset (rst, synchronous) gives levels 0, enabled, no override, idle
//   count 0, step_size 16, idle_timeout 60000 and an empty result register.
// ----------------------------------------------------------------------------
module dual_led_dimmer_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  dldc_pkg::cfg_idx_t  cfg_index,
  input  dldc_pkg::cfg_data_t cfg_data,
  dldc_cmd_if.sink            cmd,
  dldc_res_if.source          res
);

  dldc_pkg::step_t  step_size;
  dldc_pkg::ticks_t idle_timeout;
  dldc_pkg::cmd_t   cmd_word;
  dldc_pkg::res_t   res_next;
  dldc_pkg::res_t   res_q;
  logic             out_valid;
  logic             accept;

  assign cmd.ready = !out_valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign cmd_word.opcode = cmd.opcode;
  assign cmd_word.level  = cmd.level;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= dldc_pkg::STEP_SIZE_RST;
      idle_timeout <= dldc_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dldc_pkg::CFG_STEP_SIZE:    step_size    <= cfg_data[dldc_pkg::STEP_W-1:0];
        dldc_pkg::CFG_IDLE_TIMEOUT: idle_timeout <= cfg_data[dldc_pkg::TICKS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dldc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .cmd          (cmd_word),
    .step_size    (step_size),
    .idle_timeout (idle_timeout),
    .res_next     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.main_duty   = res_q.main_duty;
  assign res.second_duty = res_q.second_duty;
  assign res.is_enabled  = res_q.is_enabled;
  assign res.in_override = res_q.in_override;

endmodule

@@ hdl/dldc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldc_core: dimmer state and command decode
// Holds levels, saved copies, enable/override flags and the idle counter,
// applies one command per accepted request and forms the next result.
// ----------------------------------------------------------------------------
module dldc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  dldc_pkg::cmd_t   cmd,
  input  dldc_pkg::step_t  step_size,
  input  dldc_pkg::ticks_t idle_timeout,
  output dldc_pkg::res_t   res_next
);

  dldc_pkg::level_t main_level, main_level_next;
  dldc_pkg::level_t second_level, second_level_next;
  dldc_pkg::level_t saved_main, saved_main_next;
  dldc_pkg::level_t saved_second, saved_second_next;
  logic             enabled_flag, enabled_flag_next;
  logic             override_flag, override_flag_next;
  logic             saved_enable, saved_enable_next;
  dldc_pkg::ticks_t idle_ticks, idle_ticks_next;

  logic [dldc_pkg::LEVEL_W:0] main_up_sum, second_up_sum;
  dldc_pkg::level_t main_up, main_down, second_up, second_down;
  logic awake;

  // saturating steps
  always_comb begin
    main_up_sum   = {1'b0, main_level} + {1'b0, step_size};
    second_up_sum = {1'b0, second_level} + {1'b0, step_size};
    main_up   = main_up_sum[dldc_pkg::LEVEL_W] ? dldc_pkg::LEVEL_MAX
                                               : main_up_sum[dldc_pkg::LEVEL_W-1:0];
    second_up = second_up_sum[dldc_pkg::LEVEL_W] ? dldc_pkg::LEVEL_MAX
                                                 : second_up_sum[dldc_pkg::LEVEL_W-1:0];
    main_down   = (main_level > step_size) ? main_level - step_size : '0;
    second_down = (second_level > step_size) ? second_level - step_size : '0;
  end

  always_comb begin
    main_level_next    = main_level;
    second_level_next  = second_level;
    saved_main_next    = saved_main;
    saved_second_next  = saved_second;
    enabled_flag_next  = enabled_flag;
    override_flag_next = override_flag;
    saved_enable_next  = saved_enable;
    idle_ticks_next    = idle_ticks;
    case (cmd.opcode)
      dldc_pkg::OP_INC: begin
        if (enabled_flag) main_level_next = main_up;
      end
      dldc_pkg::OP_DEC: begin
        if (enabled_flag) main_level_next = main_down;
      end
      dldc_pkg::OP_INC2: begin
        if (enabled_flag) second_level_next = second_up;
      end
      dldc_pkg::OP_DEC2: begin
        if (enabled_flag) second_level_next = second_down;
      end
      dldc_pkg::OP_SYNC2: begin
        if (enabled_flag) second_level_next = main_level;
      end
      dldc_pkg::OP_SET: begin
        if (enabled_flag) main_level_next = cmd.level;
      end
      dldc_pkg::OP_SET2: begin
        if (enabled_flag) second_level_next = cmd.level;
      end
      dldc_pkg::OP_ON, dldc_pkg::OP_OFF, dldc_pkg::OP_TOGGLE: begin
        if (!enabled_flag && (cmd.opcode == dldc_pkg::OP_ON ||
                              cmd.opcode == dldc_pkg::OP_TOGGLE)) begin
          enabled_flag_next = 1'b1;
          main_level_next   = saved_main;
          second_level_next = saved_second;
        end else if (enabled_flag && (cmd.opcode == dldc_pkg::OP_OFF ||
                                      cmd.opcode == dldc_pkg::OP_TOGGLE)) begin
          enabled_flag_next = 1'b0;
          saved_main_next   = main_level;
          saved_second_next = second_level;
          main_level_next   = '0;
          second_level_next = '0;
        end
      end
      dldc_pkg::OP_OVR_ON: begin
        // entering override saves the current levels and enable, then drives both levels to the new level
        if (!override_flag) begin
          override_flag_next = 1'b1;
          saved_enable_next  = enabled_flag;
          saved_main_next    = main_level;
          saved_second_next  = second_level;
          enabled_flag_next  = 1'b1;
          main_level_next    = cmd.level;
          second_level_next  = cmd.level;
        end
      end
      dldc_pkg::OP_OVR_OFF: begin
        if (override_flag) begin
          override_flag_next = 1'b0;
          enabled_flag_next  = saved_enable;
          if (saved_enable) begin
            main_level_next   = saved_main;
            second_level_next = saved_second;
          end else if (enabled_flag) begin
            // going dark saves the override levels over the old ones
            saved_main_next   = main_level;
            saved_second_next = second_level;
            main_level_next   = '0;
            second_level_next = '0;
          end
        end
      end
      dldc_pkg::OP_ACTIVITY: begin
        idle_ticks_next = '0;
      end
      dldc_pkg::OP_TICK: begin
        if (idle_ticks != dldc_pkg::TICKS_MAX) idle_ticks_next = idle_ticks + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    awake = idle_ticks_next < idle_timeout;
    res_next.main_duty   = awake ? main_level_next : '0;
    res_next.second_duty = awake ? second_level_next : '0;
    res_next.is_enabled  = enabled_flag_next;
    res_next.in_override = override_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_level    <= '0;
      second_level  <= '0;
      saved_main    <= '0;
      saved_second  <= '0;
      enabled_flag  <= 1'b1;
      override_flag <= 1'b0;
      saved_enable  <= 1'b0;
      idle_ticks    <= '0;
    end else if (accept) begin
      main_level    <= main_level_next;
      second_level  <= second_level_next;
      saved_main    <= saved_main_next;
      saved_second  <= saved_second_next;
      enabled_flag  <= enabled_flag_next;
      override_flag <= override_flag_next;
      saved_enable  <= saved_enable_next;
      idle_ticks    <= idle_ticks_next;
    end
  end

`ifndef SYNTHESIS
  a_dark_when_disabled: assert property (@(posedge clk) disable iff (rst)
    !enabled_flag |-> (main_level == '0 && second_level == '0))
    else $error("levels nonzero while disabled");

  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == dldc_pkg::OP_TICK |=> idle_ticks != '0)
    else $error("tick left idle counter at zero");

  a_activity_clears: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == dldc_pkg::OP_ACTIVITY |=> idle_ticks == '0)
    else $error("activity did not clear idle counter");

  a_override_enters_on: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == dldc_pkg::OP_OVR_ON && !override_flag
    |=> override_flag && enabled_flag && main_level == $past(cmd.level))
    else $error("override entry did not take effect");
`endif

endmodule

@@ tb/dldc_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dldc_result_checker: duty and flag predictor for the dimmer controller
// Watches the command, result and register write ports, keeps its own copy
// of levels, saved levels, enable/override flags and idle count, and compares
// every result request field by field with the oldest predicted duty report.
// ----------------------------------------------------------------------------
module dldc_result_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  dldc_pkg::cfg_idx_t  cfg_index,
  input  dldc_pkg::cfg_data_t cfg_data,
  dldc_cmd_if                 cmd,
  dldc_res_if                 res,
  output int                  fail_count,
  output int                  pending
);

  // shadow state of the block
  dldc_pkg::level_t lvl_main, lvl_sec, keep_main, keep_sec;
  logic             on_flag, ovr_flag, keep_on;
  dldc_pkg::ticks_t idle_cnt;
  dldc_pkg::step_t  step_amt;
  dldc_pkg::ticks_t timeout_val;

  dldc_pkg::res_t   duty_q[$];

  // level writes only land while enabled
  function automatic void put_lvl(input bit sec, input int unsigned v);
    dldc_pkg::level_t clamped;
    clamped = (v > dldc_pkg::LEVEL_MAX) ? dldc_pkg::LEVEL_MAX : dldc_pkg::level_t'(v);
    if (on_flag) begin
      if (sec) lvl_sec = clamped;
      else lvl_main = clamped;
    end
  endfunction

  function automatic void step_up(input bit sec);
    int unsigned cur;
    cur = sec ? lvl_sec : lvl_main;
    put_lvl(sec, cur + step_amt);
  endfunction

  function automatic void step_down(input bit sec);
    int unsigned cur;
    cur = sec ? lvl_sec : lvl_main;
    put_lvl(sec, (cur > step_amt) ? cur - step_amt : 0);
  endfunction

  function automatic void switch_power(input logic want);
    if (want != on_flag) begin
      if (want) begin
        on_flag = 1'b1;
        put_lvl(1'b0, keep_main);
        put_lvl(1'b1, keep_sec);
      end else begin
        keep_main = lvl_main;
        put_lvl(1'b0, 0);
        keep_sec = lvl_sec;
        put_lvl(1'b1, 0);
        on_flag = 1'b0;
      end
    end
  endfunction

  // restore order on leaving override: power first, then saved levels
  function automatic void switch_override(input logic want, input dldc_pkg::level_t v);
    if (want != ovr_flag) begin
      ovr_flag = want;
      if (want) begin
        keep_on   = on_flag;
        keep_main = lvl_main;
        keep_sec  = lvl_sec;
        switch_power(1'b1);
        put_lvl(1'b0, v);
        put_lvl(1'b1, v);
      end else begin
        switch_power(keep_on);
        put_lvl(1'b0, keep_main);
        put_lvl(1'b1, keep_sec);
      end
    end
  endfunction

  function automatic dldc_pkg::res_t dimmer_response(input dldc_pkg::opcode_t op,
                                                     input dldc_pkg::level_t lv);
    dldc_pkg::res_t r;
    logic awake;
    case (op)
      dldc_pkg::OP_INC:      step_up(1'b0);
      dldc_pkg::OP_DEC:      step_down(1'b0);
      dldc_pkg::OP_ON:       switch_power(1'b1);
      dldc_pkg::OP_OFF:      switch_power(1'b0);
      dldc_pkg::OP_TOGGLE:   switch_power(!on_flag);
      dldc_pkg::OP_INC2:     step_up(1'b1);
      dldc_pkg::OP_DEC2:     step_down(1'b1);
      dldc_pkg::OP_SYNC2:    put_lvl(1'b1, lvl_main);
      dldc_pkg::OP_SET:      put_lvl(1'b0, lv);
      dldc_pkg::OP_SET2:     put_lvl(1'b1, lv);
      dldc_pkg::OP_OVR_ON:   switch_override(1'b1, lv);
      dldc_pkg::OP_OVR_OFF:  switch_override(1'b0, lv);
      dldc_pkg::OP_ACTIVITY: idle_cnt = '0;
      dldc_pkg::OP_TICK: begin
        if (idle_cnt != dldc_pkg::TICKS_MAX) idle_cnt = idle_cnt + 1'b1;
      end
      default: ;
    endcase
    awake = idle_cnt < timeout_val;
    r.main_duty   = awake ? lvl_main : '0;
    r.second_duty = awake ? lvl_sec : '0;
    r.is_enabled  = on_flag;
    r.in_override = ovr_flag;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    dldc_pkg::res_t want;
    if (rst) begin
      lvl_main    = '0;
      lvl_sec     = '0;
      keep_main   = '0;
      keep_sec    = '0;
      on_flag     = 1'b1;
      ovr_flag    = 1'b0;
      keep_on     = 1'b0;
      idle_cnt    = '0;
      step_amt    = dldc_pkg::STEP_SIZE_RST;
      timeout_val = dldc_pkg::IDLE_TIMEOUT_RST;
      duty_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dldc_pkg::CFG_STEP_SIZE:    step_amt = cfg_data[dldc_pkg::STEP_W-1:0];
          dldc_pkg::CFG_IDLE_TIMEOUT: timeout_val = cfg_data[dldc_pkg::TICKS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) duty_q.push_back(dimmer_response(cmd.opcode, cmd.level));
      if (res.valid && res.ready) begin
        if (duty_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0b/%0b", $time,
                   res.main_duty, res.second_duty, res.is_enabled, res.in_override);
        end else begin
          want = duty_q.pop_front();
          check_field("main_duty", want.main_duty, res.main_duty);
          check_field("second_duty", want.second_duty, res.second_duty);
          check_field("is_enabled", want.is_enabled, res.is_enabled);
          check_field("in_override", want.in_override, res.in_override);
        end
      end
    end
    pending = duty_q.size();
  end

endmodule

@@ tb/tb_dual_led_dimmer_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_led_dimmer_controller: testbench top of the dimmer controller
// Drives a directed command sequence and several register settings with
// random commands in bursts, a stalling receiver with long hold-offs, and a
// tick run across the idle timeout; the checker reports the failure count.
// ----------------------------------------------------------------------------
module tb_dual_led_dimmer_controller;

  localparam dldc_pkg::opcode_t OP_SPARE_A = 4'd14;
  localparam dldc_pkg::opcode_t OP_SPARE_B = 4'd15;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  dldc_pkg::cfg_idx_t  cfg_index;
  dldc_pkg::cfg_data_t cfg_data;
  int                  fail_count;
  int                  pending;
  int                  burst_left;

  dldc_cmd_if cmd_ch ();
  dldc_res_if res_ch ();

  dual_led_dimmer_controller u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  dldc_result_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall pattern, with a long hold-off every few segments
  initial begin : receiver
    int seg_no;
    int mode;
    int len;
    res_ch.ready = 1'b0;
    seg_no = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      seg_no++;
      if (seg_no % 12 == 3) begin
        res_ch.ready <= 1'b0;
        repeat (150) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(4, 60);
        for (int i = 0; i < len; i++) begin
          case (mode)
            0: res_ch.ready <= 1'b1;
            1: res_ch.ready <= 1'($urandom_range(0, 1));
            2: res_ch.ready <= ($urandom_range(0, 3) != 0);
            default: res_ch.ready <= (i % 3 != 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  // one command request; idle gaps fall between bursts
  task automatic send_cmd(input dldc_pkg::opcode_t op, input dldc_pkg::level_t lv);
    int gap;
    @(negedge clk);
    cmd_ch.valid  <= 1'b1;
    cmd_ch.opcode <= op;
    cmd_ch.level  <= lv;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                               : $urandom_range(0, 8);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input dldc_pkg::cfg_idx_t idx, input dldc_pkg::cfg_data_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic new_setting(input dldc_pkg::step_t step, input dldc_pkg::ticks_t timeout);
    drain();
    // upper byte of a step write is don't-care
    write_reg(dldc_pkg::CFG_STEP_SIZE, {dldc_pkg::step_t'($urandom_range(0, 255)), step});
    write_reg(dldc_pkg::CFG_IDLE_TIMEOUT, timeout);
  endtask

  task automatic run_random(input int count);
    dldc_pkg::opcode_t step_ops[4]  = '{dldc_pkg::OP_INC, dldc_pkg::OP_DEC,
                                        dldc_pkg::OP_INC2, dldc_pkg::OP_DEC2};
    dldc_pkg::opcode_t set_ops[3]   = '{dldc_pkg::OP_SET, dldc_pkg::OP_SET2,
                                        dldc_pkg::OP_SYNC2};
    dldc_pkg::opcode_t power_ops[3] = '{dldc_pkg::OP_ON, dldc_pkg::OP_OFF,
                                        dldc_pkg::OP_TOGGLE};
    int r;
    dldc_pkg::opcode_t op;
    dldc_pkg::level_t lv;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = step_ops[$urandom_range(0, 3)];
      else if (r < 42) op = set_ops[$urandom_range(0, 2)];
      else if (r < 62) op = dldc_pkg::OP_TICK;
      else if (r < 65) op = dldc_pkg::OP_ACTIVITY;
      else if (r < 76) op = power_ops[$urandom_range(0, 2)];
      else if (r < 86) op = $urandom_range(0, 1) ? dldc_pkg::OP_OVR_ON : dldc_pkg::OP_OVR_OFF;
      else op = dldc_pkg::opcode_t'($urandom_range(0, 15));
      case ($urandom_range(0, 7))
        0: lv = '0;
        1: lv = dldc_pkg::LEVEL_MAX;
        default: lv = dldc_pkg::level_t'($urandom_range(0, 255));
      endcase
      send_cmd(op, lv);
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = dldc_pkg::CFG_STEP_SIZE;
    cfg_data      = '0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.opcode = dldc_pkg::OP_INC;
    cmd_ch.level  = '0;
    burst_left    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: clamping, power save/restore, override quirks, idle, spares
    send_cmd(dldc_pkg::OP_SET, dldc_pkg::LEVEL_MAX);
    send_cmd(dldc_pkg::OP_INC, 8'h00);
    send_cmd(dldc_pkg::OP_SET, 8'h00);
    send_cmd(dldc_pkg::OP_DEC, 8'h00);
    send_cmd(dldc_pkg::OP_INC, 8'h00);
    send_cmd(dldc_pkg::OP_INC2, 8'h00);
    send_cmd(dldc_pkg::OP_DEC2, 8'h00);
    send_cmd(dldc_pkg::OP_DEC2, 8'h00);
    send_cmd(dldc_pkg::OP_SYNC2, 8'h00);
    send_cmd(dldc_pkg::OP_SET2, 8'hAA);
    send_cmd(dldc_pkg::OP_SET, 8'h55);
    send_cmd(dldc_pkg::OP_OFF, 8'h00);
    send_cmd(dldc_pkg::OP_INC, 8'h00);
    send_cmd(dldc_pkg::OP_SET, 8'hC8);
    send_cmd(dldc_pkg::OP_OFF, 8'h00);
    send_cmd(dldc_pkg::OP_ON, 8'h00);
    send_cmd(dldc_pkg::OP_ON, 8'h00);
    send_cmd(dldc_pkg::OP_TOGGLE, 8'h00);
    // override entered while disabled, then left: saved levels overwritten
    send_cmd(dldc_pkg::OP_OVR_ON, 8'hF0);
    send_cmd(dldc_pkg::OP_OVR_ON, 8'h0F);
    send_cmd(dldc_pkg::OP_OVR_OFF, 8'h00);
    send_cmd(dldc_pkg::OP_TOGGLE, 8'h00);
    send_cmd(dldc_pkg::OP_OVR_ON, 8'h64);
    send_cmd(dldc_pkg::OP_OVR_OFF, 8'h00);
    send_cmd(dldc_pkg::OP_TICK, 8'h00);
    send_cmd(dldc_pkg::OP_ACTIVITY, 8'h00);
    send_cmd(OP_SPARE_A, 8'hFF);
    send_cmd(OP_SPARE_B, 8'h00);

    new_setting(8'd255, 16'd1);
    run_random(250);
    // zero step and zero timeout
    new_setting(8'd0, 16'd0);
    run_random(200);
    new_setting(8'd1, 16'd65535);
    run_random(250);
    new_setting(dldc_pkg::step_t'($urandom_range(2, 254)),
                dldc_pkg::ticks_t'($urandom_range(3, 12)));
    run_random(400);
    new_setting(dldc_pkg::step_t'($urandom_range(2, 254)),
                dldc_pkg::ticks_t'($urandom_range(8, 30)));
    run_random(400);

    // duties go dark at the timeout and come back on activity
    new_setting(8'd16, 16'd32);
    send_cmd(dldc_pkg::OP_ON, 8'h00);
    send_cmd(dldc_pkg::OP_SET, 8'hC8);
    send_cmd(dldc_pkg::OP_SET2, 8'h4D);
    send_cmd(dldc_pkg::OP_ACTIVITY, 8'h00);
    repeat (40) send_cmd(dldc_pkg::OP_TICK, 8'h00);
    send_cmd(dldc_pkg::OP_INC, 8'h00);
    send_cmd(dldc_pkg::OP_ACTIVITY, 8'h00);

    new_setting(dldc_pkg::step_t'($urandom_range(1, 255)),
                dldc_pkg::ticks_t'($urandom_range(1, 8)));
    run_random(250);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
